FILE: rtl/csra_pkg.sv
// Shared types and constants of the conflict-aware slot and room assigner.
`default_nettype none
package csra_pkg;

  localparam int NCLS   = 64;
  localparam int NROOM  = 16;
  localparam int NSLOT  = 256;
  localparam int CLS_W  = 6;
  localparam int ROOM_W = 4;
  localparam int SLOT_W = 8;

  localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [1:0] REG_ROOM_COUNT  = 2'd1;
  localparam logic [1:0] REG_SLOT_LIMIT  = 2'd2;
  localparam logic [1:0] REG_SWEEP_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_DEMAND   = 3'd1,
    ACT_CAPACITY = 3'd2,
    ACT_CONFLICT = 3'd3,
    ACT_PLACE    = 3'd4,
    ACT_SEARCH   = 3'd5,
    ACT_READ     = 3'd6
  } act_t;

  typedef enum logic [4:0] {
    S_WIPE, S_IDLE, S_DEM_WR, S_CAP_WR, S_CF_RD, S_CF_WR,
    S_P_RD, S_P_LAT, S_REL_RD, S_REL_WR, S_P_SRD, S_P_SCHK, S_P_PICK,
    S_OCC_RD, S_OCC_WR, S_L_INIT, S_L_SWEEP, S_L_CRD, S_L_CLAT,
    S_L_SRD, S_L_SCHK, S_H_INIT, S_H_RD, S_H_CHK, S_R_RD, S_R_LAT, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_WIPE, OP_DEM_WR, OP_CAP_WR, OP_CF_WR,
    OP_P_CHECK, OP_LATCH, OP_L_LATCH, OP_REL_RD, OP_REL_WR, OP_P_SCAN,
    OP_P_PICK, OP_OCC_RD, OP_OCC_WR, OP_L_INIT, OP_L_SWEEP, OP_L_SCAN,
    OP_H_INIT, OP_H_FIN, OP_H_CHK, OP_R_LAT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ls;
  } cmd_t;

  typedef struct packed {
    logic wipe_last;
    logic wipe_full;
    logic cf_second;
    logic cls_end;
    logic asg_valid;
    logic asg_short;
    logic slots_zero;
    logic scan_last;
    logic found_any;
    logic ls_hit;
    logic ls_last;
    logic sweep_stop;
    logic improved;
  } stat_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [ROOM_W-1:0] first_one(input logic [NROOM-1:0] v);
    logic [ROOM_W-1:0] idx;
    idx = '0;
    for (int i = NROOM - 1; i >= 0; i--) begin
      if (v[i]) idx = ROOM_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/csra_ctrl.sv
// Sequencer that steps each request through the datapath operations.
`default_nettype none
module csra_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [2:0]      in_action,
  input  wire csra_pkg::stat_t stat,
  output csra_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 out_valid
);

  csra_pkg::state_t state_r, state_nxt;
  logic             ls_r, ls_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csra_pkg::S_WIPE;
      ls_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ls_r    <= ls_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ls_nxt    = ls_r;
    unique case (state_r)
      csra_pkg::S_WIPE: begin
        if (stat.wipe_last) state_nxt = stat.wipe_full ? csra_pkg::S_IDLE : csra_pkg::S_DONE;
      end
      csra_pkg::S_IDLE: begin
        if (start) begin
          ls_nxt = (csra_pkg::act_t'(in_action) == csra_pkg::ACT_SEARCH);
          case (csra_pkg::act_t'(in_action))
            csra_pkg::ACT_CLEAR:    state_nxt = csra_pkg::S_WIPE;
            csra_pkg::ACT_DEMAND:   state_nxt = csra_pkg::S_DEM_WR;
            csra_pkg::ACT_CAPACITY: state_nxt = csra_pkg::S_CAP_WR;
            csra_pkg::ACT_CONFLICT: state_nxt = csra_pkg::S_CF_RD;
            csra_pkg::ACT_PLACE:    state_nxt = csra_pkg::S_P_RD;
            csra_pkg::ACT_SEARCH:   state_nxt = csra_pkg::S_L_INIT;
            csra_pkg::ACT_READ:     state_nxt = csra_pkg::S_R_RD;
            default:                state_nxt = csra_pkg::S_DONE;
          endcase
        end
      end
      csra_pkg::S_DEM_WR, csra_pkg::S_CAP_WR: state_nxt = csra_pkg::S_DONE;
      csra_pkg::S_CF_RD: state_nxt = csra_pkg::S_CF_WR;
      csra_pkg::S_CF_WR: state_nxt = stat.cf_second ? csra_pkg::S_DONE : csra_pkg::S_CF_RD;
      csra_pkg::S_P_RD:  state_nxt = stat.cls_end ? csra_pkg::S_DONE : csra_pkg::S_P_LAT;
      csra_pkg::S_P_LAT: begin
        if (stat.asg_valid)       state_nxt = csra_pkg::S_REL_RD;
        else if (stat.slots_zero) state_nxt = csra_pkg::S_P_PICK;
        else                      state_nxt = csra_pkg::S_P_SRD;
      end
      csra_pkg::S_REL_RD: state_nxt = csra_pkg::S_REL_WR;
      csra_pkg::S_REL_WR: begin
        if (ls_r)                 state_nxt = csra_pkg::S_OCC_RD;
        else if (stat.slots_zero) state_nxt = csra_pkg::S_P_PICK;
        else                      state_nxt = csra_pkg::S_P_SRD;
      end
      csra_pkg::S_P_SRD:  state_nxt = csra_pkg::S_P_SCHK;
      csra_pkg::S_P_SCHK: state_nxt = stat.scan_last ? csra_pkg::S_P_PICK : csra_pkg::S_P_SRD;
      csra_pkg::S_P_PICK: state_nxt = stat.found_any ? csra_pkg::S_OCC_RD : csra_pkg::S_DONE;
      csra_pkg::S_OCC_RD: state_nxt = csra_pkg::S_OCC_WR;
      csra_pkg::S_OCC_WR: state_nxt = ls_r ? csra_pkg::S_L_CRD : csra_pkg::S_DONE;
      csra_pkg::S_L_INIT: state_nxt = csra_pkg::S_L_SWEEP;
      csra_pkg::S_L_SWEEP: state_nxt = stat.sweep_stop ? csra_pkg::S_H_INIT : csra_pkg::S_L_CRD;
      csra_pkg::S_L_CRD: begin
        if (!stat.cls_end)     state_nxt = csra_pkg::S_L_CLAT;
        else if (stat.improved) state_nxt = csra_pkg::S_L_SWEEP;
        else                   state_nxt = csra_pkg::S_H_INIT;
      end
      csra_pkg::S_L_CLAT: state_nxt = stat.asg_short ? csra_pkg::S_L_CRD : csra_pkg::S_L_SRD;
      csra_pkg::S_L_SRD:  state_nxt = csra_pkg::S_L_SCHK;
      csra_pkg::S_L_SCHK: begin
        if (stat.ls_hit)       state_nxt = csra_pkg::S_REL_RD;
        else if (stat.ls_last) state_nxt = csra_pkg::S_L_CRD;
        else                   state_nxt = csra_pkg::S_L_SRD;
      end
      csra_pkg::S_H_INIT: state_nxt = csra_pkg::S_H_RD;
      csra_pkg::S_H_RD:   state_nxt = stat.cls_end ? csra_pkg::S_DONE : csra_pkg::S_H_CHK;
      csra_pkg::S_H_CHK:  state_nxt = csra_pkg::S_H_RD;
      csra_pkg::S_R_RD:   state_nxt = csra_pkg::S_R_LAT;
      csra_pkg::S_R_LAT:  state_nxt = csra_pkg::S_DONE;
      csra_pkg::S_DONE:   state_nxt = csra_pkg::S_IDLE;
      default:            state_nxt = csra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ls    = ls_r;
    busy      = (state_r != csra_pkg::S_IDLE);
    out_valid = (state_r == csra_pkg::S_DONE);
    unique case (state_r)
      csra_pkg::S_WIPE:    cmd.op = csra_pkg::OP_WIPE;
      csra_pkg::S_IDLE:    cmd.op = start ? csra_pkg::OP_CAPTURE : csra_pkg::OP_NONE;
      csra_pkg::S_DEM_WR:  cmd.op = csra_pkg::OP_DEM_WR;
      csra_pkg::S_CAP_WR:  cmd.op = csra_pkg::OP_CAP_WR;
      csra_pkg::S_CF_WR:   cmd.op = csra_pkg::OP_CF_WR;
      csra_pkg::S_P_RD:    cmd.op = csra_pkg::OP_P_CHECK;
      csra_pkg::S_P_LAT:   cmd.op = csra_pkg::OP_LATCH;
      csra_pkg::S_L_CLAT:  cmd.op = csra_pkg::OP_L_LATCH;
      csra_pkg::S_REL_RD:  cmd.op = csra_pkg::OP_REL_RD;
      csra_pkg::S_REL_WR:  cmd.op = csra_pkg::OP_REL_WR;
      csra_pkg::S_P_SCHK:  cmd.op = csra_pkg::OP_P_SCAN;
      csra_pkg::S_P_PICK:  cmd.op = csra_pkg::OP_P_PICK;
      csra_pkg::S_OCC_RD:  cmd.op = csra_pkg::OP_OCC_RD;
      csra_pkg::S_OCC_WR:  cmd.op = csra_pkg::OP_OCC_WR;
      csra_pkg::S_L_INIT:  cmd.op = csra_pkg::OP_L_INIT;
      csra_pkg::S_L_SWEEP: cmd.op = csra_pkg::OP_L_SWEEP;
      csra_pkg::S_L_SCHK:  cmd.op = csra_pkg::OP_L_SCAN;
      csra_pkg::S_H_INIT:  cmd.op = csra_pkg::OP_H_INIT;
      csra_pkg::S_H_RD:    cmd.op = csra_pkg::OP_H_FIN;
      csra_pkg::S_H_CHK:   cmd.op = csra_pkg::OP_H_CHK;
      csra_pkg::S_R_LAT:   cmd.op = csra_pkg::OP_R_LAT;
      default:             cmd.op = csra_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/csra_dp.sv
// Datapath: problem memories, occupancy memories, scan counters and result registers.
`default_nettype none
module csra_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_data,
  input  wire logic [csra_pkg::CLS_W-1:0]   in_class_index,
  input  wire logic [csra_pkg::CLS_W-1:0]   in_other_class,
  input  wire logic [csra_pkg::ROOM_W-1:0]  in_room_index,
  input  wire logic [15:0]                  in_amount,
  input  wire csra_pkg::cmd_t               cmd,
  output csra_pkg::stat_t                   stat,
  output logic                              out_status,
  output logic [8:0]                        out_slot_number,
  output logic [4:0]                        out_room_number,
  output logic [8:0]                        out_highest_slot,
  output logic [15:0]                       out_sweeps_done
);

  localparam int NCLS   = csra_pkg::NCLS;
  localparam int NROOM  = csra_pkg::NROOM;
  localparam int NSLOT  = csra_pkg::NSLOT;
  localparam int CLS_W  = csra_pkg::CLS_W;
  localparam int ROOM_W = csra_pkg::ROOM_W;
  localparam int SLOT_W = csra_pkg::SLOT_W;

  // Configuration registers.
  logic [6:0]  class_count_r;
  logic [4:0]  room_count_r;
  logic [8:0]  slot_bound_r;
  logic [15:0] sweep_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= 7'd64;
      room_count_r  <= 5'd16;
      slot_bound_r  <= 9'd256;
      sweep_limit_r <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csra_pkg::REG_CLASS_COUNT: class_count_r <= cfg_data[6:0];
        csra_pkg::REG_ROOM_COUNT:  room_count_r  <= cfg_data[4:0];
        csra_pkg::REG_SLOT_LIMIT:  slot_bound_r  <= cfg_data[8:0];
        csra_pkg::REG_SWEEP_LIMIT: sweep_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [6:0] classes_eff;
  logic [4:0] rooms_eff;
  logic [8:0] slots_eff;
  assign classes_eff = (class_count_r > 7'(NCLS)) ? 7'(NCLS) : class_count_r;
  assign rooms_eff   = (room_count_r > 5'(NROOM)) ? 5'(NROOM) : room_count_r;
  assign slots_eff   = (slot_bound_r > 9'(NSLOT)) ? 9'(NSLOT) : slot_bound_r;

  // Working registers.
  logic [6:0]        cls_r;
  logic [CLS_W-1:0]  oth_r;
  logic [ROOM_W-1:0] ridx_r;
  logic [15:0]       amount_r;
  logic [8:0]        clr_r;
  logic              full_r;
  logic              cf_second_r;
  logic [8:0]        slot_r;
  logic [8:0]        old_slot_r;
  logic [4:0]        old_room_r;
  logic [15:0]       dem_r;
  logic [NCLS-1:0]   row_r;
  logic [NROOM-1:0]  found_v_r;
  logic [SLOT_W-1:0] found_s_r [NROOM];
  logic [SLOT_W-1:0] tgt_slot_r;
  logic [ROOM_W-1:0] tgt_room_r;
  logic [15:0]       sweeps_r;
  logic              improved_r;
  logic [8:0]        high_r;
  logic [15:0]       cap_r [NROOM];

  // Memory read data.
  logic [NROOM-1:0] busy_q;
  logic [NCLS-1:0]  memb_q;
  logic [8:0]       asg_slot_q;
  logic [4:0]       asg_room_q;
  logic [15:0]      dem_q;
  logic [NCLS-1:0]  conf_q;

  // Per-room lanes: room in use and large enough for the class under work.
  logic [NROOM-1:0] cap_ok;
  always_comb begin
    for (int r = 0; r < NROOM; r++) begin
      cap_ok[r] = (5'(r) < rooms_eff) && (cap_r[r] >= dem_r);
    end
  end

  logic              slot_clear;
  logic [NROOM-1:0]  cand;
  logic [NROOM-1:0]  place_new;
  logic [ROOM_W-1:0] pick_room;
  logic [ROOM_W-1:0] cand_room;
  logic [NCLS-1:0]   cls_bit;
  logic [NCLS-1:0]   oth_bit;
  logic [NROOM-1:0]  old_room_bit;
  logic [NROOM-1:0]  tgt_room_bit;

  assign slot_clear   = ((memb_q & row_r) == '0);
  assign cand         = slot_clear ? (cap_ok & ~busy_q) : '0;
  assign place_new    = cap_ok & ~busy_q & ~found_v_r & {NROOM{slot_clear}};
  assign pick_room    = csra_pkg::first_one(found_v_r);
  assign cand_room    = csra_pkg::first_one(cand);
  assign cls_bit      = NCLS'(1) << cls_r[CLS_W-1:0];
  assign oth_bit      = NCLS'(1) << oth_r;
  assign old_room_bit = NROOM'(1) << ROOM_W'(old_room_r - 5'd1);
  assign tgt_room_bit = NROOM'(1) << tgt_room_r;

  always_comb begin
    stat.wipe_last  = (clr_r == 9'(NSLOT - 1));
    stat.wipe_full  = full_r;
    stat.cf_second  = cf_second_r;
    stat.cls_end    = (cls_r >= classes_eff);
    stat.asg_valid  = (asg_slot_q != 9'd0);
    stat.asg_short  = (asg_slot_q <= 9'd1);
    stat.slots_zero = (slots_eff == 9'd0);
    stat.scan_last  = ({1'b0, slot_r} + 10'd1 >= {1'b0, slots_eff});
    stat.found_any  = (found_v_r != '0);
    stat.ls_hit     = (cand != '0);
    stat.ls_last    = ({1'b0, slot_r} + 10'd2 >= {1'b0, old_slot_r});
    stat.sweep_stop = (sweeps_r >= sweep_limit_r);
    stat.improved   = improved_r;
  end

  // Occupancy memory, one row per slot: room busy bits and member classes.
  logic [NROOM-1:0]  busy_mem [NSLOT];
  logic [NCLS-1:0]   memb_mem [NSLOT];
  logic [SLOT_W-1:0] s_addr;
  logic              s_we;
  logic [NROOM-1:0]  s_busy_d;
  logic [NCLS-1:0]   s_memb_d;

  always_comb begin
    s_addr   = slot_r[SLOT_W-1:0];
    s_we     = 1'b0;
    s_busy_d = '0;
    s_memb_d = '0;
    unique case (cmd.op)
      csra_pkg::OP_WIPE: begin
        s_addr = clr_r[SLOT_W-1:0];
        s_we   = 1'b1;
      end
      csra_pkg::OP_REL_RD: s_addr = SLOT_W'(old_slot_r - 9'd1);
      csra_pkg::OP_REL_WR: begin
        s_addr   = SLOT_W'(old_slot_r - 9'd1);
        s_we     = 1'b1;
        s_busy_d = busy_q & ~old_room_bit;
        s_memb_d = memb_q & ~cls_bit;
      end
      csra_pkg::OP_OCC_RD: s_addr = tgt_slot_r;
      csra_pkg::OP_OCC_WR: begin
        s_addr   = tgt_slot_r;
        s_we     = 1'b1;
        s_busy_d = busy_q | tgt_room_bit;
        s_memb_d = memb_q | cls_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      busy_mem[s_addr] <= s_busy_d;
      memb_mem[s_addr] <= s_memb_d;
    end
    busy_q <= busy_mem[s_addr];
    memb_q <= memb_mem[s_addr];
  end

  // Per-class memories: assignment, demand and conflict row.
  logic [8:0]       asg_slot_mem [NCLS];
  logic [4:0]       asg_room_mem [NCLS];
  logic [15:0]      dem_mem [NCLS];
  logic [NCLS-1:0]  conf_mem [NCLS];
  logic [CLS_W-1:0] c_addr;
  logic             a_we;
  logic [8:0]       a_slot_d;
  logic [4:0]       a_room_d;
  logic             d_we;
  logic [15:0]      d_d;
  logic             f_we;
  logic [NCLS-1:0]  f_d;

  always_comb begin
    c_addr   = cls_r[CLS_W-1:0];
    a_we     = 1'b0;
    a_slot_d = '0;
    a_room_d = '0;
    d_we     = 1'b0;
    d_d      = '0;
    f_we     = 1'b0;
    f_d      = '0;
    unique case (cmd.op)
      csra_pkg::OP_WIPE: begin
        c_addr = clr_r[CLS_W-1:0];
        a_we   = 1'b1;
        d_we   = full_r;
        f_we   = full_r;
      end
      csra_pkg::OP_REL_WR: a_we = !cmd.ls;
      csra_pkg::OP_OCC_WR: begin
        a_we     = 1'b1;
        a_slot_d = {1'b0, tgt_slot_r} + 9'd1;
        a_room_d = {1'b0, tgt_room_r} + 5'd1;
      end
      csra_pkg::OP_DEM_WR: begin
        d_we = 1'b1;
        d_d  = amount_r;
      end
      csra_pkg::OP_CF_WR: begin
        f_we = 1'b1;
        f_d  = conf_q | oth_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      asg_slot_mem[c_addr] <= a_slot_d;
      asg_room_mem[c_addr] <= a_room_d;
    end
    if (d_we) dem_mem[c_addr] <= d_d;
    if (f_we) conf_mem[c_addr] <= f_d;
    asg_slot_q <= asg_slot_mem[c_addr];
    asg_room_q <= asg_room_mem[c_addr];
    dem_q      <= dem_mem[c_addr];
    conf_q     <= conf_mem[c_addr];
  end

  // Control registers that reset initializes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      full_r <= 1'b1;
      for (int r = 0; r < NROOM; r++) cap_r[r] <= '0;
    end else begin
      unique case (cmd.op)
        csra_pkg::OP_CAPTURE: clr_r <= '0;
        csra_pkg::OP_WIPE: begin
          clr_r <= clr_r + 9'd1;
          if (stat.wipe_last) full_r <= 1'b0;
        end
        csra_pkg::OP_CAP_WR: cap_r[ridx_r] <= amount_r;
        default: ;
      endcase
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      csra_pkg::OP_CAPTURE: begin
        cls_r            <= {1'b0, in_class_index};
        oth_r            <= in_other_class;
        ridx_r           <= in_room_index;
        amount_r         <= in_amount;
        cf_second_r      <= 1'b0;
        out_status       <= 1'b0;
        out_slot_number  <= '0;
        out_room_number  <= '0;
        out_highest_slot <= '0;
        out_sweeps_done  <= '0;
      end
      csra_pkg::OP_CF_WR: begin
        cls_r       <= {1'b0, oth_r};
        oth_r       <= cls_r[CLS_W-1:0];
        cf_second_r <= 1'b1;
      end
      csra_pkg::OP_P_CHECK: begin
        if (stat.cls_end) out_status <= 1'b1;
      end
      csra_pkg::OP_LATCH, csra_pkg::OP_L_LATCH: begin
        old_slot_r <= asg_slot_q;
        old_room_r <= asg_room_q;
        dem_r      <= dem_q;
        row_r      <= conf_q;
        slot_r     <= '0;
        found_v_r  <= '0;
        if (cmd.op == csra_pkg::OP_L_LATCH && stat.asg_short) cls_r <= cls_r + 7'd1;
      end
      csra_pkg::OP_P_SCAN: begin
        for (int r = 0; r < NROOM; r++) begin
          if (place_new[r]) begin
            found_v_r[r] <= 1'b1;
            found_s_r[r] <= slot_r[SLOT_W-1:0];
          end
        end
        slot_r <= slot_r + 9'd1;
      end
      csra_pkg::OP_P_PICK: begin
        if (stat.found_any) begin
          tgt_room_r <= pick_room;
          tgt_slot_r <= found_s_r[pick_room];
        end else begin
          out_status <= 1'b1;
        end
      end
      csra_pkg::OP_OCC_WR: begin
        if (cmd.ls) begin
          cls_r      <= cls_r + 7'd1;
          improved_r <= 1'b1;
        end else begin
          out_slot_number <= {1'b0, tgt_slot_r} + 9'd1;
          out_room_number <= {1'b0, tgt_room_r} + 5'd1;
        end
      end
      csra_pkg::OP_L_INIT: sweeps_r <= '0;
      csra_pkg::OP_L_SWEEP: begin
        if (!stat.sweep_stop) begin
          sweeps_r   <= sweeps_r + 16'd1;
          improved_r <= 1'b0;
          cls_r      <= '0;
        end
      end
      csra_pkg::OP_L_SCAN: begin
        if (stat.ls_hit) begin
          tgt_slot_r <= slot_r[SLOT_W-1:0];
          tgt_room_r <= cand_room;
        end else begin
          slot_r <= slot_r + 9'd1;
          if (stat.ls_last) cls_r <= cls_r + 7'd1;
        end
      end
      csra_pkg::OP_H_INIT: begin
        cls_r  <= '0;
        high_r <= '0;
      end
      csra_pkg::OP_H_FIN: begin
        if (stat.cls_end) begin
          out_highest_slot <= high_r;
          out_sweeps_done  <= sweeps_r;
        end
      end
      csra_pkg::OP_H_CHK: begin
        if (asg_slot_q > high_r) high_r <= asg_slot_q;
        cls_r <= cls_r + 7'd1;
      end
      csra_pkg::OP_R_LAT: begin
        out_slot_number <= asg_slot_q;
        out_room_number <= asg_room_q;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/conflict_aware_slot_room_assigner.sv
// Top level of the conflict-aware slot and room assigner.
//
//   Channel  Handshake               Payload
//   in       start / busy            in_action, in_class_index, in_other_class,
//                                    in_room_index, in_amount
//   out      out_valid (one cycle)   out_status, out_slot_number, out_room_number,
//                                    out_highest_slot, out_sweeps_done
//   cfg      cfg_we                  cfg_index, cfg_data
//
// A request is taken when start is high and busy is low; one request is
// worked on at a time, and its single result shows for one cycle with
// out_valid, after which busy drops the next cycle.
// Clear makes one pass over the 256 occupancy rows, one row a cycle.
// Place scans the slots in order, up to the slot bound register; local
// search tries the lower slots of each class, repeated per sweep, then
// reads every class for the highest slot. These scans, one row of the
// occupancy memory per read, set the rate.
// After reset the same clearing pass also zeroes demands and conflicts;
// busy stays high during that pass. Configuration writes are taken
// at any time. The receiver cannot hold off a result.
`default_nettype none
module conflict_aware_slot_room_assigner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [5:0]  in_class_index,
  input  wire logic [5:0]  in_other_class,
  input  wire logic [3:0]  in_room_index,
  input  wire logic [15:0] in_amount,
  output logic             out_valid,
  output logic             out_status,
  output logic [8:0]       out_slot_number,
  output logic [4:0]       out_room_number,
  output logic [8:0]       out_highest_slot,
  output logic [15:0]      out_sweeps_done,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // The sequencer issues one datapath operation per cycle and branches on
  // the status flags that the datapath returns.
  csra_pkg::cmd_t  cmd;
  csra_pkg::stat_t stat;

  csra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds every memory, the configuration registers and the
  // result registers, which stay stable while out_valid is high.
  csra_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_class_index   (in_class_index),
    .in_other_class   (in_other_class),
    .in_room_index    (in_room_index),
    .in_amount        (in_amount),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_slot_number  (out_slot_number),
    .out_room_number  (out_room_number),
    .out_highest_slot (out_highest_slot),
    .out_sweeps_done  (out_sweeps_done)
  );

`ifndef SYNTHESIS
  // A result only appears while a request is in progress.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  // Each result is shown for exactly one cycle and the block then frees up.
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result not a single pulse");

  // A taken request makes the block busy in the next cycle.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken without going busy");

  // A failed placement reports no slot and no room.
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_slot_number == 9'd0 && out_room_number == 5'd0)
    else $error("failure with an assignment");
`endif

endmodule
`default_nettype wire

FILE: tb/conflict_aware_slot_room_assigner_test.sv
// Self-checking testbench for the conflict-aware slot and room assigner.
`default_nettype none
module conflict_aware_slot_room_assigner_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code 7 has no meaning; the block must answer it with all zeros.
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  // Cycles without any accepted request or answer before the run is called hung.
  localparam int STALL_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 20;

  // One answer of the block, field by field.
  typedef struct packed {
    logic        status;
    logic [8:0]  slot;
    logic [4:0]  room;
    logic [8:0]  high;
    logic [15:0] sweeps;
  } answer_t;

  // One directed request; typed answers stand only where they are obvious.
  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  cls;
    logic [5:0]  other;
    logic [3:0]  room;
    logic [15:0] amount;
    logic        typed;
    answer_t     answer;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_action = '0;
  logic [5:0]  in_class_index = '0;
  logic [5:0]  in_other_class = '0;
  logic [3:0]  in_room_index = '0;
  logic [15:0] in_amount = '0;
  logic        out_valid;
  logic        out_status;
  logic [8:0]  out_slot_number;
  logic [4:0]  out_room_number;
  logic [8:0]  out_highest_slot;
  logic [15:0] out_sweeps_done;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  conflict_aware_slot_room_assigner u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_class_index(in_class_index),
    .in_other_class(in_other_class), .in_room_index(in_room_index),
    .in_amount(in_amount), .out_valid(out_valid), .out_status(out_status),
    .out_slot_number(out_slot_number), .out_room_number(out_room_number),
    .out_highest_slot(out_highest_slot), .out_sweeps_done(out_sweeps_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's problem, occupancy and registers.
  logic [6:0]  m_class_count;
  logic [4:0]  m_room_count;
  logic [8:0]  m_slot_bound;
  logic [15:0] m_sweep_limit;
  logic [15:0] m_demand [csra_pkg::NCLS];
  logic [15:0] m_capacity [csra_pkg::NROOM];
  logic [63:0] m_conflicts [csra_pkg::NCLS];
  logic [8:0]  m_slot_of [csra_pkg::NCLS];
  logic [4:0]  m_room_of [csra_pkg::NCLS];
  logic [255:0] m_room_taken [csra_pkg::NROOM];
  logic [63:0] m_members [csra_pkg::NSLOT];

  answer_t pending_answers[$];
  int errors = 0;
  int requests_sent = 0;
  int answers_seen = 0;
  int places_ok = 0;
  int places_failed = 0;
  int searches = 0;
  int configs_written = 0;

  function automatic void clear_occupancy();
    for (int i = 0; i < csra_pkg::NCLS; i++) begin
      m_slot_of[i] = '0;
      m_room_of[i] = '0;
    end
    for (int r = 0; r < csra_pkg::NROOM; r++) m_room_taken[r] = '0;
    for (int s = 0; s < csra_pkg::NSLOT; s++) m_members[s] = '0;
  endfunction

  function automatic void take_seat(int c, int r, int s);
    m_slot_of[c] = 9'(s + 1);
    m_room_of[c] = 5'(r + 1);
    m_room_taken[r][s] = 1'b1;
    m_members[s][c] = 1'b1;
  endfunction

  function automatic void free_seat(int c);
    if (m_slot_of[c] != 0 && m_room_of[c] != 0) begin
      m_room_taken[m_room_of[c] - 1][m_slot_of[c] - 1] = 1'b0;
      m_members[m_slot_of[c] - 1][c] = 1'b0;
    end
    m_slot_of[c] = '0;
    m_room_of[c] = '0;
  endfunction

  function automatic bit seat_class(int c);
    int rooms;
    int slots;
    rooms = (m_room_count > csra_pkg::NROOM) ? csra_pkg::NROOM : int'(m_room_count);
    slots = (m_slot_bound > csra_pkg::NSLOT) ? csra_pkg::NSLOT : int'(m_slot_bound);
    free_seat(c);
    for (int r = 0; r < rooms; r++) begin
      if (m_capacity[r] < m_demand[c]) continue;
      for (int s = 0; s < slots; s++) begin
        if (m_room_taken[r][s] || (m_conflicts[c] & m_members[s]) != 0) continue;
        take_seat(c, r, s);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Sweeps pulling every class down to its earliest feasible lower slot.
  function automatic int compact_slots();
    int classes;
    int rooms;
    int sweeps;
    bit improved;
    bit moved;
    int cur;
    classes = (m_class_count > csra_pkg::NCLS) ? csra_pkg::NCLS : int'(m_class_count);
    rooms = (m_room_count > csra_pkg::NROOM) ? csra_pkg::NROOM : int'(m_room_count);
    sweeps = 0;
    improved = 1'b1;
    while (improved && sweeps < int'(m_sweep_limit)) begin
      improved = 1'b0;
      sweeps++;
      for (int i = 0; i < classes; i++) begin
        cur = m_slot_of[i];
        moved = 1'b0;
        for (int ns = 1; ns < cur && !moved; ns++) begin
          for (int r = 0; r < rooms; r++) begin
            if (m_capacity[r] < m_demand[i]) continue;
            if (m_room_taken[r][ns - 1]) continue;
            if ((m_conflicts[i] & m_members[ns - 1]) != 0) continue;
            free_seat(i);
            take_seat(i, r, ns - 1);
            improved = 1'b1;
            moved = 1'b1;
            break;
          end
        end
      end
    end
    return sweeps;
  endfunction

  // Applies one request to the shadow state and returns the answer due.
  function automatic answer_t predict_answer(logic [2:0] action, logic [5:0] c,
                                            logic [5:0] o, logic [3:0] r,
                                            logic [15:0] amount);
    answer_t a;
    int classes;
    a = '0;
    case (action)
      csra_pkg::ACT_CLEAR: clear_occupancy();
      csra_pkg::ACT_DEMAND: m_demand[c] = amount;
      csra_pkg::ACT_CAPACITY: m_capacity[r] = amount;
      csra_pkg::ACT_CONFLICT: begin
        m_conflicts[c][o] = 1'b1;
        m_conflicts[o][c] = 1'b1;
      end
      csra_pkg::ACT_PLACE: begin
        classes = (m_class_count > csra_pkg::NCLS) ? csra_pkg::NCLS : int'(m_class_count);
        if (int'(c) < classes && seat_class(int'(c))) begin
          a.slot = m_slot_of[c];
          a.room = m_room_of[c];
          places_ok++;
        end else begin
          a.status = 1'b1;
          places_failed++;
        end
      end
      csra_pkg::ACT_SEARCH: begin
        a.sweeps = 16'(compact_slots());
        classes = (m_class_count > csra_pkg::NCLS) ? csra_pkg::NCLS : int'(m_class_count);
        for (int i = 0; i < classes; i++)
          if (m_slot_of[i] > a.high) a.high = m_slot_of[i];
        searches++;
      end
      csra_pkg::ACT_READ: begin
        a.slot = m_slot_of[c];
        a.room = m_room_of[c];
      end
      default: ;
    endcase
    return a;
  endfunction

  // Drives one request and holds it until the block takes it. Start is left
  // high so that a back-to-back request never lowers and raises it in one step.
  task automatic issue_request(logic [2:0] action, logic [5:0] c, logic [5:0] o,
                               logic [3:0] r, logic [15:0] amount, bit typed,
                               answer_t typed_answer);
    answer_t predicted;
    start <= 1'b1;
    in_action <= action;
    in_class_index <= c;
    in_other_class <= o;
    in_room_index <= r;
    in_amount <= amount;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_answer(action, c, o, r, amount);
    pending_answers.push_back(typed ? typed_answer : predicted);
    requests_sent++;
  endtask

  // Sender gaps: light at first, heavy in the middle, none at the end.
  task automatic maybe_pause();
    int pct;
    pct = (requests_sent < 55) ? 10 : (requests_sent < 110) ? 46 : 0;
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Waits for the block to drain before a register is touched.
  task automatic wait_idle();
    @(posedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0 || busy) @(posedge clk);
  endtask

  // Drives one register write; the caller lowers the write enable afterwards.
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      csra_pkg::REG_CLASS_COUNT: m_class_count = value[6:0];
      csra_pkg::REG_ROOM_COUNT:  m_room_count = value[4:0];
      csra_pkg::REG_SLOT_LIMIT:  m_slot_bound = value[8:0];
      default:                   m_sweep_limit = value;
    endcase
    configs_written++;
  endtask

  // Random request mix of loads, placements, searches, reads, rare clears and unused codes, with
  // small demands and capacities so that placements both succeed and fail.
  task automatic random_request();
    int pick;
    logic [2:0] action;
    logic [15:0] amount;
    pick = $urandom_range(99);
    if (pick < 14) action = csra_pkg::ACT_DEMAND;
    else if (pick < 24) action = csra_pkg::ACT_CAPACITY;
    else if (pick < 38) action = csra_pkg::ACT_CONFLICT;
    else if (pick < 72) action = csra_pkg::ACT_PLACE;
    else if (pick < 80) action = csra_pkg::ACT_SEARCH;
    else if (pick < 94) action = csra_pkg::ACT_READ;
    else if (pick < 97) action = csra_pkg::ACT_CLEAR;
    else action = ACT_UNUSED;
    amount = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
    issue_request(action, ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15)),
                  6'($urandom), 4'($urandom), amount, 1'b0, '0);
  endtask

  // Compares each answer with the oldest one still due.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer status=%0d slot=%0d room=%0d", $time,
                 out_status, out_slot_number, out_room_number);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_slot_number !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_slot_number);
          errors++;
        end
        if (out_room_number !== want.room) begin
          $display("%0t: room expected %0d actual %0d", $time, want.room, out_room_number);
          errors++;
        end
        if (out_highest_slot !== want.high) begin
          $display("%0t: highest slot expected %0d actual %0d", $time, want.high,
                   out_highest_slot);
          errors++;
        end
        if (out_sweeps_done !== want.sweeps) begin
          $display("%0t: sweeps expected %0d actual %0d", $time, want.sweeps,
                   out_sweeps_done);
          errors++;
        end
      end
    end
  end

  // Hang detector: any accepted request or answer restarts the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Register settings per phase: the smallest, values past the maximum that must
  // saturate, zero counts, two in between, and the full counts with a sweep limit of 2.
  logic [15:0] phase_regs [6][4] = '{
    '{16'd1,   16'd1,  16'd1,   16'd0},
    '{16'd127, 16'd31, 16'd511, 16'd65535},
    '{16'd0,   16'd0,  16'd0,   16'd1},
    '{16'd8,   16'd3,  16'd6,   16'd5},
    '{16'd20,  16'd4,  16'd12,  16'd10000},
    '{16'd64,  16'd16, 16'd256, 16'd2}
  };

  // Directed opening: field extremes, every action and the special cases.
  directed_row_t directed [21] = '{
    '{csra_pkg::ACT_READ,     6'd0,  6'd0,  4'd0,  16'd0,    1'b1, answer_t'('0)},
    '{ACT_UNUSED,             6'd63, 6'd63, 4'd15, 16'hFFFF, 1'b1, answer_t'('0)},
    '{csra_pkg::ACT_DEMAND,   6'd63, 6'd0,  4'd0,  16'hFFFF, 1'b1, answer_t'('0)},
    '{csra_pkg::ACT_CAPACITY, 6'd0,  6'd0,  4'd15, 16'hFFFF, 1'b1, answer_t'('0)},
    '{csra_pkg::ACT_CONFLICT, 6'd0,  6'd63, 4'd0,  16'd0,    1'b1, answer_t'('0)},
    '{csra_pkg::ACT_CONFLICT, 6'd5,  6'd5,  4'd0,  16'd0,    1'b1, answer_t'('0)},
    // Class 0 needs nothing, so the first room and slot take it.
    '{csra_pkg::ACT_PLACE,    6'd0,  6'd0,  4'd0,  16'd0,    1'b1,
      answer_t'({1'b0, 9'd1, 5'd1, 25'd0})},
    '{csra_pkg::ACT_PLACE,    6'd63, 6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_PLACE,    6'd5,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_PLACE,    6'd0,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_READ,     6'd63, 6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_DEMAND,   6'd1,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_CONFLICT, 6'd1,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_PLACE,    6'd1,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_DEMAND,   6'd2,  6'd0,  4'd0,  16'h8000, 1'b0, answer_t'('0)},
    '{csra_pkg::ACT_PLACE,    6'd2,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_SEARCH,   6'd0,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_READ,     6'd1,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)},
    '{csra_pkg::ACT_CLEAR,    6'd0,  6'd0,  4'd0,  16'd0,    1'b1, answer_t'('0)},
    '{csra_pkg::ACT_READ,     6'd2,  6'd0,  4'd0,  16'd0,    1'b1, answer_t'('0)},
    '{csra_pkg::ACT_SEARCH,   6'd0,  6'd0,  4'd0,  16'd0,    1'b0, answer_t'('0)}
  };

  initial begin
    m_class_count = 7'd64;
    m_room_count = 5'd16;
    m_slot_bound = 9'd256;
    m_sweep_limit = 16'd10000;
    for (int i = 0; i < csra_pkg::NCLS; i++) begin
      m_demand[i] = '0;
      m_conflicts[i] = '0;
    end
    for (int r = 0; r < csra_pkg::NROOM; r++) m_capacity[r] = '0;
    clear_occupancy();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    foreach (directed[k]) begin
      issue_request(directed[k].action, directed[k].cls, directed[k].other,
                    directed[k].room, directed[k].amount, directed[k].typed,
                    directed[k].answer);
      maybe_pause();
    end

    // Random phases, each under a new set of register values.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      for (int g = 0; g < 4; g++) write_reg(2'(g), phase_regs[p][g]);
      cfg_we <= 1'b0;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        random_request();
        maybe_pause();
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Sent %0d requests over %0d register writes, %0d answers checked.",
             requests_sent, configs_written, answers_seen);
    $display("Placements: %0d seated, %0d refused; %0d compaction passes.",
             places_ok, places_failed, searches);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
